FILE: src/waypoint_follow_motor_drive_assert.svh
// ----------------------------------------------------------------------------
// waypoint follow motor drive assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOW_MOTOR_DRIVE_ASSERT_SVH
`define WAYPOINT_FOLLOW_MOTOR_DRIVE_ASSERT_SVH

// same-cycle implication, masked during reset
`define WFMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define WFMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wfmd_pkg.sv
// ----------------------------------------------------------------------------
// wfmd_pkg
// types and constants of the waypoint follow motor drive
// ----------------------------------------------------------------------------
`default_nettype none

package wfmd_pkg;

    // route store geometry
    localparam int ROUTE_DEPTH = 256;
    localparam int ROUTE_AW    = $clog2(ROUTE_DEPTH);
    localparam int ROUTE_W     = 64;

    // apb register window
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // datapath widths
    localparam int WAYPOINT_W = 9;
    localparam int ERR_W      = 34;
    localparam int SUM_W      = 35;
    localparam int MAG_W      = 12;
    localparam int QUO_W      = 9;

    // divide by 12 and by 10 as multiply by reciprocal, exact below 4096
    localparam logic [MAG_W-1:0] MAG_MAX     = 12'd4095;
    localparam logic [MAG_W-1:0] DIST_RECIP  = 12'd2731;
    localparam logic [MAG_W-1:0] TURN_RECIP  = 12'd3277;
    localparam int               RECIP_SHIFT = 15;

    // register indexes
    localparam logic [2:0] REG_TOLERANCE     = 3'd0;
    localparam logic [2:0] REG_COMMON_FLOOR  = 3'd1;
    localparam logic [2:0] REG_COMMON_CEIL   = 3'd2;
    localparam logic [2:0] REG_WHEEL_CEIL    = 3'd3;
    localparam logic [2:0] REG_TURN_LIMIT    = 3'd4;
    localparam logic [2:0] REG_ENC_TIMEOUT   = 3'd5;
    localparam logic [2:0] REG_MIN_DRIVE     = 3'd6;
    localparam logic [2:0] REG_ROUTE_LENGTH  = 3'd7;

    // register reset values
    localparam logic [15:0] TOLERANCE_RST    = 16'd100;
    localparam logic [7:0]  COMMON_FLOOR_RST = 8'd45;
    localparam logic [7:0]  COMMON_CEIL_RST  = 8'd80;
    localparam logic [7:0]  WHEEL_CEIL_RST   = 8'd120;
    localparam logic [7:0]  TURN_LIMIT_RST   = 8'd35;
    localparam logic [15:0] ENC_TIMEOUT_RST  = 16'd250;
    localparam logic [7:0]  MIN_DRIVE_RST    = 8'd80;
    localparam logic [8:0]  ROUTE_LENGTH_RST = 9'd0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } follow_state_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_TIMEOUT  = 2'd1,
        CAUSE_FINISHED = 2'd2
    } stop_cause_t;

    // result fields settled in the decision stage, carried to the output
    typedef struct packed {
        logic                  update;
        follow_state_t         status;
        logic [WAYPOINT_W-1:0] waypoint;
        logic                  rejected;
        stop_cause_t           cause;
        logic                  drive;
    } result_info_t;

endpackage

`default_nettype wire

FILE: src/wfmd_ram.sv
// ----------------------------------------------------------------------------
// wfmd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wfmd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/waypoint_follow_motor_drive.sv
// ----------------------------------------------------------------------------
// waypoint_follow_motor_drive
// two wheel waypoint follower with route memory and pwm mixing pipeline
// ----------------------------------------------------------------------------
// steps from request accept to result valid: route read at accept, then decide,
//   sum and difference, divide and clamp, mix into the output register
// throughput: one request per cycle unless results stall; the route read at accept
//   takes the waypoint index forwarded by the decision stage, so ticks need no bubble
// reset: registers return to their defaults, follow state idle, index and
//   baselines zero; the route memory is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_follow_motor_drive
    import wfmd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // apb configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic      [DATA_W-1:0]       prdata,
    output logic                         pready,

    // request channel
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire logic [1:0]              cmd,
    input  wire logic [31:0]             now_ms,
    input  wire logic [31:0]             last_rx_ms,
    input  wire logic                    encoder_seen,
    input  wire logic signed [31:0]      total_left,
    input  wire logic signed [31:0]      total_right,
    input  wire logic [7:0]              load_index,
    input  wire logic signed [31:0]      load_left,
    input  wire logic signed [31:0]      load_right,

    // result channel
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic                         motor_update,
    output logic      [7:0]              motor_left,
    output logic      [7:0]              motor_right,
    output logic      [1:0]              run_status,
    output logic      [WAYPOINT_W-1:0]   current_waypoint,
    output logic                         start_rejected,
    output logic      [1:0]              stop_cause
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]           tolerance_reg;
    logic [7:0]            common_floor_reg;
    logic [7:0]            common_ceil_reg;
    logic [7:0]            wheel_ceil_reg;
    logic [7:0]            turn_limit_reg;
    logic [15:0]           enc_timeout_reg;
    logic [7:0]            min_drive_reg;
    logic [WAYPOINT_W-1:0] route_length_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg    <= TOLERANCE_RST;
            common_floor_reg <= COMMON_FLOOR_RST;
            common_ceil_reg  <= COMMON_CEIL_RST;
            wheel_ceil_reg   <= WHEEL_CEIL_RST;
            turn_limit_reg   <= TURN_LIMIT_RST;
            enc_timeout_reg  <= ENC_TIMEOUT_RST;
            min_drive_reg    <= MIN_DRIVE_RST;
            route_length_reg <= ROUTE_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TOLERANCE:    tolerance_reg    <= pwdata[15:0];
                REG_COMMON_FLOOR: common_floor_reg <= pwdata[7:0];
                REG_COMMON_CEIL:  common_ceil_reg  <= pwdata[7:0];
                REG_WHEEL_CEIL:   wheel_ceil_reg   <= pwdata[7:0];
                REG_TURN_LIMIT:   turn_limit_reg   <= pwdata[7:0];
                REG_ENC_TIMEOUT:  enc_timeout_reg  <= pwdata[15:0];
                REG_MIN_DRIVE:    min_drive_reg    <= pwdata[7:0];
                REG_ROUTE_LENGTH: route_length_reg <= pwdata[WAYPOINT_W-1:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            REG_TOLERANCE:    prdata = {16'd0, tolerance_reg};
            REG_COMMON_FLOOR: prdata = {24'd0, common_floor_reg};
            REG_COMMON_CEIL:  prdata = {24'd0, common_ceil_reg};
            REG_WHEEL_CEIL:   prdata = {24'd0, wheel_ceil_reg};
            REG_TURN_LIMIT:   prdata = {24'd0, turn_limit_reg};
            REG_ENC_TIMEOUT:  prdata = {16'd0, enc_timeout_reg};
            REG_MIN_DRIVE:    prdata = {24'd0, min_drive_reg};
            REG_ROUTE_LENGTH: prdata = {{(DATA_W-WAYPOINT_W){1'b0}}, route_length_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when the next one has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, result_valid_reg;
    logic out_free, s4_free, s3_free, s2_free, s1_free;
    logic accept, s1_adv;

    assign out_free   = !result_valid_reg || result_ready;
    assign s4_free    = !s4_valid_reg || out_free;
    assign s3_free    = !s3_valid_reg || s4_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item_ready = s1_free;
    assign accept     = item_valid && item_ready;
    assign s1_adv     = s1_valid_reg && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                result_valid_reg <= s4_valid_reg;
            end
        end
    end

    assign result_valid = result_valid_reg;

    // ------------------------------------------------------------------
    // stage 1: request capture and route memory access
    // loads write at accept; ticks read the slot of the forwarded index
    // ------------------------------------------------------------------
    logic [1:0]         s1_cmd_reg;
    logic [31:0]        s1_now_reg;
    logic [31:0]        s1_last_reg;
    logic               s1_seen_reg;
    logic signed [31:0] s1_total_l_reg;
    logic signed [31:0] s1_total_r_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg     <= cmd;
            s1_now_reg     <= now_ms;
            s1_last_reg    <= last_rx_ms;
            s1_seen_reg    <= encoder_seen;
            s1_total_l_reg <= total_left;
            s1_total_r_reg <= total_right;
        end
    end

    logic                  ram_we;
    logic                  ram_re;
    logic [ROUTE_AW-1:0]   ram_raddr;
    logic [ROUTE_W-1:0]    ram_rdata;
    logic [WAYPOINT_W-1:0] pos_next;

    assign ram_we    = accept && (cmd == CMD_LOAD);
    assign ram_re    = accept && (cmd != CMD_LOAD);
    // forwarded index: covers a tick that advances in this same cycle
    assign ram_raddr = pos_next[ROUTE_AW-1:0];

    wfmd_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (ROUTE_DEPTH)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_index[ROUTE_AW-1:0]),
        .wdata ({load_left, load_right}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 2: freshness, wheel errors, follow state update
    // ------------------------------------------------------------------
    follow_state_t         state_reg, state_next;
    logic [WAYPOINT_W-1:0] pos_reg;
    logic signed [31:0]    base_l_reg, base_l_next;
    logic signed [31:0]    base_r_reg, base_r_next;

    logic [31:0]             age;
    logic                    fresh;
    logic signed [32:0]      dist_l, dist_r;
    logic signed [ERR_W-1:0] err_l, err_r;
    logic signed [ERR_W-1:0] tol_pos, tol_neg;
    logic                    reached;
    logic [WAYPOINT_W-1:0]   route_len;
    logic                    at_end;

    assign age     = s1_now_reg - s1_last_reg;
    assign fresh   = s1_seen_reg && (age <= {16'd0, enc_timeout_reg});

    // travel since start, then error against the target, widened so nothing wraps
    assign dist_l  = {s1_total_l_reg[31], s1_total_l_reg} - {base_l_reg[31], base_l_reg};
    assign dist_r  = {s1_total_r_reg[31], s1_total_r_reg} - {base_r_reg[31], base_r_reg};
    assign err_l   = $signed({{2{ram_rdata[63]}}, ram_rdata[63:32]}) - $signed({dist_l[32], dist_l});
    assign err_r   = $signed({{2{ram_rdata[31]}}, ram_rdata[31:0]}) - $signed({dist_r[32], dist_r});

    assign tol_pos = $signed({{(ERR_W-16){1'b0}}, tolerance_reg});
    assign tol_neg = -tol_pos;
    assign reached = (err_l <= tol_pos) && (err_l >= tol_neg)
                  && (err_r <= tol_pos) && (err_r >= tol_neg);

    // route length saturates at the store depth
    assign route_len = (route_length_reg > WAYPOINT_W'(ROUTE_DEPTH))
                     ? WAYPOINT_W'(ROUTE_DEPTH) : route_length_reg;
    assign at_end    = (pos_reg >= route_len);

    // next state
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        base_l_next = base_l_reg;
        base_r_next = base_r_reg;
        if (s1_adv)
        begin
            case (s1_cmd_reg)
                CMD_START:
                begin
                    if (fresh)
                    begin
                        state_next  = ST_RUN;
                        pos_next    = '0;
                        base_l_next = s1_total_l_reg;
                        base_r_next = s1_total_r_reg;
                    end
                end
                CMD_TICK:
                begin
                    if (state_reg == ST_RUN)
                    begin
                        if (!fresh || at_end)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (reached)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // loads and unused codes leave the follower alone
                end
            endcase
        end
    end

    // result fields of the decision
    result_info_t s2_info;

    always_comb
    begin
        s2_info          = '0;
        s2_info.status   = state_next;
        s2_info.waypoint = pos_next;
        s2_info.cause    = CAUSE_NONE;
        case (s1_cmd_reg)
            CMD_START:
            begin
                s2_info.update   = 1'b1;
                s2_info.rejected = !fresh;
            end
            CMD_TICK:
            begin
                if (state_reg == ST_RUN)
                begin
                    if (!fresh)
                    begin
                        s2_info.update = 1'b1;
                        s2_info.cause  = CAUSE_TIMEOUT;
                    end
                    else if (at_end)
                    begin
                        s2_info.update = 1'b1;
                        s2_info.cause  = CAUSE_FINISHED;
                    end
                    else if (!reached)
                    begin
                        s2_info.update = 1'b1;
                        s2_info.drive  = 1'b1;
                    end
                end
            end
            default:
            begin
                s2_info.update = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            base_l_reg <= '0;
            base_r_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            base_l_reg <= base_l_next;
            base_r_reg <= base_r_next;
        end
    end

    result_info_t            s2_info_reg;
    logic signed [ERR_W-1:0] s2_err_l_reg, s2_err_r_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_info_reg  <= s2_info;
            s2_err_l_reg <= err_l;
            s2_err_r_reg <= err_r;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: forward and turn terms as sign and saturated magnitude
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] err_sum, err_diff;
    logic [SUM_W-1:0]        sum_abs, diff_abs;
    logic [SUM_W-2:0]        sum_half;
    logic [MAG_W-1:0]        c_mag, d_mag;

    assign err_sum  = $signed({s2_err_l_reg[ERR_W-1], s2_err_l_reg})
                    + $signed({s2_err_r_reg[ERR_W-1], s2_err_r_reg});
    assign err_diff = $signed({s2_err_l_reg[ERR_W-1], s2_err_l_reg})
                    - $signed({s2_err_r_reg[ERR_W-1], s2_err_r_reg});
    assign sum_abs  = err_sum[SUM_W-1] ? SUM_W'(-err_sum) : SUM_W'(err_sum);
    assign diff_abs = err_diff[SUM_W-1] ? SUM_W'(-err_diff) : SUM_W'(err_diff);

    // halving with truncation toward zero is a shift of the magnitude
    assign sum_half = sum_abs[SUM_W-1:1];
    // past 4095 every quotient already sits beyond any 8-bit clamp
    assign c_mag    = (sum_half > (SUM_W-1)'(MAG_MAX)) ? MAG_MAX : sum_half[MAG_W-1:0];
    assign d_mag    = (diff_abs > SUM_W'(MAG_MAX)) ? MAG_MAX : diff_abs[MAG_W-1:0];

    result_info_t     s3_info_reg;
    logic             s3_c_neg_reg, s3_d_neg_reg;
    logic [MAG_W-1:0] s3_c_mag_reg, s3_d_mag_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_info_reg  <= s2_info_reg;
            s3_c_neg_reg <= err_sum[SUM_W-1];
            s3_d_neg_reg <= err_diff[SUM_W-1];
            s3_c_mag_reg <= c_mag;
            s3_d_mag_reg <= d_mag;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: divide by reciprocal multiply, clamp forward and turn terms
    // ------------------------------------------------------------------
    logic [2*MAG_W-1:0] prod_c, prod_d;
    logic [QUO_W-1:0]   quo_c, quo_d;
    logic signed [10:0] q_c, q_d;
    logic signed [10:0] floor_s, ceil_s, lim_s;
    logic [7:0]         cp;
    logic signed [8:0]  tp;

    assign prod_c  = s3_c_mag_reg * DIST_RECIP;
    assign prod_d  = s3_d_mag_reg * TURN_RECIP;
    assign quo_c   = prod_c[RECIP_SHIFT +: QUO_W];
    assign quo_d   = prod_d[RECIP_SHIFT +: QUO_W];
    assign q_c     = s3_c_neg_reg ? -$signed({2'b00, quo_c}) : $signed({2'b00, quo_c});
    assign q_d     = s3_d_neg_reg ? -$signed({2'b00, quo_d}) : $signed({2'b00, quo_d});
    assign floor_s = $signed({3'b000, common_floor_reg});
    assign ceil_s  = $signed({3'b000, common_ceil_reg});
    assign lim_s   = $signed({3'b000, turn_limit_reg});

    // lower bound checked first; with crossed clamps, values below the floor take the floor, all others the ceiling
    always_comb
    begin
        if (q_c < floor_s)
        begin
            cp = common_floor_reg;
        end
        else if (q_c > ceil_s)
        begin
            cp = common_ceil_reg;
        end
        else
        begin
            cp = q_c[7:0];
        end

        if (q_d < -lim_s)
        begin
            tp = 9'(-lim_s);
        end
        else if (q_d > lim_s)
        begin
            tp = 9'(lim_s);
        end
        else
        begin
            tp = 9'(q_d);
        end
    end

    result_info_t      s4_info_reg;
    logic [7:0]        s4_cp_reg;
    logic signed [8:0] s4_tp_reg;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_free)
        begin
            s4_info_reg <= s3_info_reg;
            s4_cp_reg   <= cp;
            s4_tp_reg   <= tp;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: mix into wheel pwm, clamp, raise to minimum drive
    // ------------------------------------------------------------------
    logic signed [9:0] mix_l, mix_r;
    logic [7:0]        clamp_l, clamp_r;
    logic [7:0]        pwm_l, pwm_r;

    assign mix_l = $signed({2'b00, s4_cp_reg}) + $signed({s4_tp_reg[8], s4_tp_reg});
    assign mix_r = $signed({2'b00, s4_cp_reg}) - $signed({s4_tp_reg[8], s4_tp_reg});

    always_comb
    begin
        if (mix_l < 0)
        begin
            clamp_l = '0;
        end
        else if (mix_l > $signed({2'b00, wheel_ceil_reg}))
        begin
            clamp_l = wheel_ceil_reg;
        end
        else
        begin
            clamp_l = mix_l[7:0];
        end

        if (mix_r < 0)
        begin
            clamp_r = '0;
        end
        else if (mix_r > $signed({2'b00, wheel_ceil_reg}))
        begin
            clamp_r = wheel_ceil_reg;
        end
        else
        begin
            clamp_r = mix_r[7:0];
        end

        // a small nonzero drive would stall the wheel, so lift it
        pwm_l = ((clamp_l != 8'd0) && (clamp_l < min_drive_reg)) ? min_drive_reg : clamp_l;
        pwm_r = ((clamp_r != 8'd0) && (clamp_r < min_drive_reg)) ? min_drive_reg : clamp_r;
    end

    // output register: holds a result while stalled; requests behind it move on only into empty stages
    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && out_free)
        begin
            motor_update     <= s4_info_reg.update;
            motor_left       <= s4_info_reg.drive ? pwm_l : 8'd0;
            motor_right      <= s4_info_reg.drive ? pwm_r : 8'd0;
            run_status       <= s4_info_reg.status;
            current_waypoint <= s4_info_reg.waypoint;
            start_rejected   <= s4_info_reg.rejected;
            stop_cause       <= s4_info_reg.cause;
        end
    end

endmodule

`default_nettype wire

FILE: src/wfmd_checker.sv
// ----------------------------------------------------------------------------
// wfmd_checker
// port level checks of the waypoint follow motor drive results
// ----------------------------------------------------------------------------
`default_nettype none

`include "waypoint_follow_motor_drive_assert.svh"

module wfmd_checker
    import wfmd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic                  motor_update,
    input wire logic [7:0]            motor_left,
    input wire logic [7:0]            motor_right,
    input wire logic [1:0]            run_status,
    input wire logic [WAYPOINT_W-1:0] current_waypoint,
    input wire logic                  start_rejected,
    input wire logic [1:0]            stop_cause
);

    // stalled result holds its payload
    `WFMD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(motor_left) && $stable(motor_right) && $stable(current_waypoint) && $stable(run_status), "result changed while stalled")

    // no motor command means both wheels read zero
    `WFMD_ASSERT_SAME(a_idle_motors, clk, rst_n, result_valid && !motor_update, (motor_left == 8'd0) && (motor_right == 8'd0), "pwm without motor update")

    // a rejected start stops the motors and names no stop cause
    `WFMD_ASSERT_SAME(a_reject_stop, clk, rst_n, result_valid && start_rejected, motor_update && (stop_cause == CAUSE_NONE) && (motor_left == 8'd0) && (motor_right == 8'd0), "rejected start drove motors")

    // any stop cause ends the run with motors off
    `WFMD_ASSERT_SAME(a_stop_done, clk, rst_n, result_valid && (stop_cause != CAUSE_NONE), motor_update && (run_status == ST_DONE) && (motor_left == 8'd0) && (motor_right == 8'd0), "stop without done state")

endmodule

bind waypoint_follow_motor_drive wfmd_checker u_wfmd_checker (.*);

`default_nettype wire
